// ===== src/cdmc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdmc_pkg
// Shared types, constants and helpers of the clock display mode controller.
// ----------------------------------------------------------------------------
package cdmc_pkg;

    localparam int NUM_BUTTONS   = 3;
    localparam int PRESS_SAMPLES = 12;
    localparam logic [15:0] DB_FILL  = 16'((32'hFFFF << (PRESS_SAMPLES + 1)) & 32'hFFFF);
    localparam logic [15:0] DB_PRESS = DB_FILL | 16'(1 << PRESS_SAMPLES);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_TUBE   = 2'd0,
        KIND_REG    = 2'd1,
        KIND_SUPPLY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_SHOW  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    localparam logic [1:0] REG_MINUTES = 2'd1;
    localparam logic [1:0] REG_HOURS   = 2'd2;

    typedef struct packed {
        logic [2:0] st;
        logic [3:0] so;
        logic [2:0] mt;
        logic [3:0] mo;
        logic       ht;
        logic [3:0] ho;
        logic       pm;
    } tm_t;

    // one tick's item as handed from the front part to the back part
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] lv;
        logic                   time_valid;
        tm_t                    rtc;
    } tick_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] d1;
        logic [3:0] d2;
        logic [3:0] d3;
        logic [3:0] d4;
        logic       dot;
        logic [1:0] addr;
        logic [7:0] data;
        logic       supply;
        logic       last;
    } result_t;

    function automatic logic [15:0] db_shift(input logic [15:0] r, input logic lv);
        db_shift = {r[14:0], lv} | DB_FILL;
    endfunction

    function automatic logic [4:0] hval(input tm_t t);
        hval = 5'({4'b0, t.ht} * 5'd10 + {1'b0, t.ho});
    endfunction

    function automatic logic [6:0] mval(input tm_t t);
        mval = 7'({4'b0, t.mt} * 7'd10 + {3'b0, t.mo});
    endfunction

    function automatic logic same_time(input tm_t a, input tm_t b);
        same_time = (a.pm == b.pm) && (hval(a) == hval(b)) && (mval(a) == mval(b));
    endfunction

    function automatic tm_t inc_hours(input tm_t t);
        tm_t        r;
        logic [4:0] h;
        r = t;
        h = hval(t);
        if (h < 5'd9) begin
            r.ho = t.ho + 4'd1;
        end else if (h == 5'd9) begin
            r.ht = 1'b1;
            r.ho = 4'd0;
        end else if (h < 5'd12) begin
            r.ho = t.ho + 4'd1;
            if (h == 5'd11) r.pm = ~t.pm;
        end else begin
            r.ht = 1'b0;
            r.ho = 4'd1;
        end
        inc_hours = r;
    endfunction

    function automatic tm_t inc_minutes(input tm_t t);
        tm_t r;
        r = t;
        // ones digit mod 10 equal to 9 covers 9 only (4-bit values 0..15)
        if (t.mo != 4'd9) begin
            r.mo = t.mo + 4'd1;
        end else if (t.mt == 3'd5) begin
            r.mo = 4'd0;
            r.mt = 3'd0;
            r = inc_hours(r);
        end else begin
            r.mo = 4'd0;
            r.mt = t.mt + 3'd1;
        end
        inc_minutes = r;
    endfunction

endpackage

// ===== src/clock_display_mode_controller.sv =====
// ----------------------------------------------------------------------------
// clock_display_mode_controller
// Button, mode and schedule controller of a four-tube clock display.
// ----------------------------------------------------------------------------
// One input transaction is one loop tick: three raw button levels (0 pressed)
// and an optional real-time-clock reading loaded when time_valid is high.
// Each tick yields zero to three result transactions on the m_ channel:
// tube updates, rtc register writes and supply switches, the final one of a
// tick flagged by m_last.
// Ticks pass an input register and a two-entry queue; the tick engine takes a
// tick when its result buffer is empty or its final result leaves, and hands
// results out one per cycle while m_ready is high. A tick is held in the input
// register, a queue entry and the result buffer before its first result shows;
// the single result port sets the sustained tick rate.
// Reset clears debouncers, mode (show time), times and counters and turns the
// supply on. When the receiver stalls, results hold in the buffer and the
// queue absorbs up to three further ticks before s_ready falls.
// ----------------------------------------------------------------------------
module clock_display_mode_controller
    import cdmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_hour_button_level,
    input  logic       s_minute_button_level,
    input  logic       s_mode_button_level,
    input  logic       s_time_valid,
    input  logic [2:0] s_rtc_second_tens,
    input  logic [3:0] s_rtc_second_ones,
    input  logic [2:0] s_rtc_minute_tens,
    input  logic [3:0] s_rtc_minute_ones,
    input  logic       s_rtc_hour_tens,
    input  logic [3:0] s_rtc_hour_ones,
    input  logic       s_rtc_pm,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [3:0] m_digit_first,
    output logic [3:0] m_digit_second,
    output logic [3:0] m_digit_third,
    output logic [3:0] m_digit_fourth,
    output logic       m_dot_on,
    output logic [1:0] m_reg_addr,
    output logic [7:0] m_reg_data,
    output logic       m_supply_on,
    output logic       m_last
);

    tm_t     rtc;
    logic    f_valid, f_ready, b_valid, b_ready;
    tick_t   f_data, b_data;
    result_t res;

    assign rtc = '{st: s_rtc_second_tens, so: s_rtc_second_ones,
                   mt: s_rtc_minute_tens, mo: s_rtc_minute_ones,
                   ht: s_rtc_hour_tens, ho: s_rtc_hour_ones, pm: s_rtc_pm};

    cdmc_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready,
        .hour_level(s_hour_button_level), .minute_level(s_minute_button_level),
        .mode_level(s_mode_button_level), .time_valid(s_time_valid), .rtc,
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    cdmc_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    cdmc_back u_back (
        .aclk, .aresetn,
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .m_valid, .m_ready, .m_data(res)
    );

    assign m_kind         = res.kind;
    assign m_digit_first  = res.d1;
    assign m_digit_second = res.d2;
    assign m_digit_third  = res.d3;
    assign m_digit_fourth = res.d4;
    assign m_dot_on       = res.dot;
    assign m_reg_addr     = res.addr;
    assign m_reg_data     = res.data;
    assign m_supply_on    = res.supply;
    assign m_last         = res.last;

endmodule

// ===== src/cdmc_queue.sv =====
// ----------------------------------------------------------------------------
// cdmc_queue
// Two-entry tick queue between the front and the back part.
// ----------------------------------------------------------------------------
module cdmc_queue
    import cdmc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  tick_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output tick_t rd_data
);

    tick_t      mem_reg [QUEUE_DEPTH];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign wr_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wptr_next  = do_wr ? ~wptr_reg : wptr_reg;
        rptr_next  = do_rd ? ~rptr_reg : rptr_reg;
        count_next = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wptr_reg] <= wr_data;
    end

endmodule

// ===== src/cdmc_front.sv =====
// ----------------------------------------------------------------------------
// cdmc_front
// Input stage: captures the tick transaction and packs it for the queue.
// ----------------------------------------------------------------------------
module cdmc_front
    import cdmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       hour_level,
    input  logic       minute_level,
    input  logic       mode_level,
    input  logic       time_valid,
    input  tm_t        rtc,
    output logic       q_valid,
    input  logic       q_ready,
    output tick_t      q_data
);

    logic  valid_reg;
    tick_t data_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg.lv         <= {mode_level, minute_level, hour_level};
            data_reg.time_valid <= time_valid;
            data_reg.rtc        <= rtc;
        end
    end

endmodule

// ===== src/cdmc_back.sv =====
// ----------------------------------------------------------------------------
// cdmc_back
// Tick engine: debounce, mode logic and result sequencing.
// ----------------------------------------------------------------------------
module cdmc_back
    import cdmc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  tick_t   q_data,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic [15:0] press_reg [NUM_BUTTONS];
    logic [15:0] hold_reg  [NUM_BUTTONS];
    mode_t       mode_reg;
    logic        power_reg;
    logic        override_reg;
    tm_t         ct_reg;
    tm_t         sched_reg [2];
    logic [9:0]  dot_reg;
    logic [7:0]  ccount_reg;
    logic [3:0]  cdigit_reg;

    // pending results of the current tick (up to three)
    result_t     res_reg [3];
    logic [1:0]  res_cnt_reg;
    logic [1:0]  res_idx_reg;

    logic [15:0] press_next [NUM_BUTTONS];
    logic [15:0] hold_next  [NUM_BUTTONS];
    mode_t       mode_next;
    logic        power_next, override_next;
    tm_t         ct_next;
    tm_t         sched_next [2];
    logic [9:0]  dot_next;
    logic [7:0]  ccount_next;
    logic [3:0]  cdigit_next;
    result_t     res_next [3];
    logic [1:0]  res_cnt_next;

    logic busy, take;

    assign busy    = (res_idx_reg != res_cnt_reg);
    // a new tick may enter while the final result of the previous one leaves
    assign q_ready = !busy || (m_ready && (res_idx_reg + 2'd1 == res_cnt_reg));
    assign take    = q_valid && q_ready;
    assign m_valid = busy;
    assign m_data  = res_reg[res_idx_reg];

    function automatic result_t mk(input kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        mk = r;
    endfunction

    always_comb begin
        tm_t        ct, ed;
        logic [5:0] v;
        logic [3:0] tens, ones;
        logic [9:0] top;
        logic       p0, p1, p2, h0, h1;
        logic [1:0] n;
        result_t    tube;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            press_next[b] = press_reg[b];
            hold_next[b]  = hold_reg[b];
        end
        mode_next     = mode_reg;
        power_next    = power_reg;
        override_next = override_reg;
        sched_next[0] = sched_reg[0];
        sched_next[1] = sched_reg[1];
        dot_next      = dot_reg;
        ccount_next   = ccount_reg;
        cdigit_next   = cdigit_reg;
        for (int k = 0; k < 3; k++) res_next[k] = '0;
        n    = 2'd0;
        top  = 10'd255;
        ed   = '0;
        tens = 4'd0;
        ones = 4'd0;
        v    = 6'd0;
        tube = mk(KIND_TUBE);
        p0 = 1'b0; p1 = 1'b0; p2 = 1'b0; h0 = 1'b0; h1 = 1'b0;

        ct = q_data.time_valid ? q_data.rtc : ct_reg;

        if (!power_reg) begin
            // short-circuit order: each evaluated check shifts its register
            press_next[0] = db_shift(press_reg[0], q_data.lv[0]);
            p0 = (press_next[0] == DB_PRESS);
            if (!p0) begin
                press_next[1] = db_shift(press_reg[1], q_data.lv[1]);
                p1 = (press_next[1] == DB_PRESS);
                if (!p1) begin
                    press_next[2] = db_shift(press_reg[2], q_data.lv[2]);
                    p2 = (press_next[2] == DB_PRESS);
                end
            end
            if (p0 || p1 || p2) begin
                power_next    = 1'b1;
                override_next = 1'b1;
                res_next[0]   = mk(KIND_SUPPLY);
                res_next[0].supply = 1'b1;
                n = 2'd1;
            end else if (same_time(ct, sched_reg[1])) begin
                power_next    = 1'b1;
                override_next = 1'b0;
                res_next[0]   = mk(KIND_SUPPLY);
                res_next[0].supply = 1'b1;
                n = 2'd1;
            end
        end else begin
            hold_next[0] = db_shift(hold_reg[0], q_data.lv[0]);
            h0 = (hold_next[0] == DB_FILL);
            if (h0) begin
                hold_next[1] = db_shift(hold_reg[1], q_data.lv[1]);
                h1 = (hold_next[1] == DB_FILL);
            end
            if (h0 && h1) begin
                sched_next[0] = '0;
                sched_next[1] = '0;
            end else begin
                press_next[2] = db_shift(press_reg[2], q_data.lv[2]);
                if (press_next[2] == DB_PRESS) begin
                    mode_next = (mode_reg == MODE_STOP) ? MODE_SHOW
                                                        : mode_t'(mode_reg + 2'd1);
                end else if (mode_reg != MODE_SHOW) begin
                    unique case (mode_reg)
                        MODE_SET:   begin ed = ct;           top = 10'd255;  end
                        MODE_START: begin ed = sched_reg[0]; top = 10'd511;  end
                        default:    begin ed = sched_reg[1]; top = 10'd1023; end
                    endcase
                    press_next[0] = db_shift(press_reg[0], q_data.lv[0]);
                    if (press_next[0] == DB_PRESS) begin
                        ed = inc_hours(ed);
                    end else begin
                        press_next[1] = db_shift(press_reg[1], q_data.lv[1]);
                        if (press_next[1] == DB_PRESS) ed = inc_minutes(ed);
                    end
                    dot_next = (dot_reg >= top) ? 10'd0 : dot_reg + 10'd1;
                    tens = {3'b0, ed.ht};
                    ones = ed.ho;
                    if (ed.pm) begin
                        if (!(ed.ht && ed.ho == 4'd2)) begin
                            // hour value up to 25, so the shifted hour reaches 37
                            v = {1'b0, hval(ed)} + 6'd12;
                            tens = (v >= 6'd30) ? 4'd3 : (v >= 6'd20) ? 4'd2 :
                                   (v >= 6'd10) ? 4'd1 : 4'd0;
                            ones = 4'(v - {2'b0, tens} * 6'd10);
                        end
                    end else if (ed.ht && ed.ho == 4'd2) begin
                        tens = 4'd0;
                        ones = 4'd0;
                    end
                    tube.d1  = ed.mo;
                    tube.d2  = {1'b0, ed.mt};
                    tube.d3  = ones;
                    tube.d4  = tens;
                    tube.dot = (dot_next < 10'd128);
                    res_next[0] = tube;
                    n = 2'd1;
                    unique case (mode_reg)
                        MODE_SET: begin
                            ct = ed;
                            res_next[1] = mk(KIND_REG);
                            res_next[1].addr = REG_MINUTES;
                            res_next[1].data = {1'b0, ed.mt, ed.mo};
                            res_next[2] = mk(KIND_REG);
                            res_next[2].addr = REG_HOURS;
                            res_next[2].data = {2'b01, ed.pm, ed.ht, ed.ho};
                            n = 2'd3;
                        end
                        MODE_START: sched_next[0] = ed;
                        default:    sched_next[1] = ed;
                    endcase
                end else if (!ct.pm && hval(ct) == 5'd3 && mval(ct) < 7'd30) begin
                    ccount_next = ccount_reg + 8'd1;
                    if (ccount_next == 8'd255) begin
                        cdigit_next = (cdigit_reg == 4'd9) ? 4'd0 : cdigit_reg + 4'd1;
                    end
                    tube.d1 = cdigit_next;
                    tube.d2 = cdigit_next;
                    tube.d3 = cdigit_next;
                    tube.d4 = cdigit_next;
                    res_next[0] = tube;
                    n = 2'd1;
                end else begin
                    // the hour button hold is sampled a second time here
                    hold_next[0] = db_shift(hold_next[0], q_data.lv[0]);
                    if (hold_next[0] == DB_FILL) begin
                        tube.d1  = ct.so;
                        tube.d2  = {1'b0, ct.st};
                        tube.d3  = ct.mo;
                        tube.d4  = {1'b0, ct.mt};
                        tube.dot = 1'b1;
                        res_next[0] = tube;
                        n = 2'd1;
                    end else begin
                        tube.d1  = ct.mo;
                        tube.d2  = {1'b0, ct.mt};
                        tube.d3  = ct.ho;
                        tube.d4  = {3'b0, ct.ht};
                        tube.dot = 1'b1;
                        if (!override_reg && same_time(ct, sched_reg[0])) begin
                            if (!same_time(sched_reg[1], sched_reg[0])) begin
                                power_next    = 1'b0;
                                override_next = 1'b0;
                                res_next[0]   = mk(KIND_SUPPLY);
                                res_next[1]   = tube;
                                n = 2'd2;
                            end else begin
                                res_next[0] = tube;
                                n = 2'd1;
                            end
                        end else begin
                            if (same_time(ct, sched_reg[1])) override_next = 1'b0;
                            res_next[0] = tube;
                            n = 2'd1;
                        end
                    end
                end
            end
        end
        ct_next = ct;
        if (n != 2'd0) res_next[n - 2'd1].last = 1'b1;
        res_cnt_next = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                press_reg[b] <= '0;
                hold_reg[b]  <= '0;
            end
            mode_reg     <= MODE_SHOW;
            power_reg    <= 1'b1;
            override_reg <= 1'b0;
            ct_reg       <= '0;
            sched_reg[0] <= '0;
            sched_reg[1] <= '0;
            dot_reg      <= '0;
            ccount_reg   <= '0;
            cdigit_reg   <= '0;
            res_cnt_reg  <= '0;
            res_idx_reg  <= '0;
        end else if (take) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                press_reg[b] <= press_next[b];
                hold_reg[b]  <= hold_next[b];
            end
            mode_reg     <= mode_next;
            power_reg    <= power_next;
            override_reg <= override_next;
            ct_reg       <= ct_next;
            sched_reg[0] <= sched_next[0];
            sched_reg[1] <= sched_next[1];
            dot_reg      <= dot_next;
            ccount_reg   <= ccount_next;
            cdigit_reg   <= cdigit_next;
            res_cnt_reg  <= res_cnt_next;
            res_idx_reg  <= '0;
        end else if (busy && m_ready) begin
            res_idx_reg <= res_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int k = 0; k < 3; k++) res_reg[k] <= res_next[k];
        end
    end

endmodule

// ===== src/cdmc_checker.sv =====
// ----------------------------------------------------------------------------
// cdmc_checker
// Port-level checks of the clock display mode controller.
// ----------------------------------------------------------------------------
module cdmc_checker
    import cdmc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [1:0] m_reg_addr,
    input logic       m_supply_on,
    input logic       m_last
);

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_TUBE || m_kind == KIND_REG || m_kind == KIND_SUPPLY))
        else $error("illegal result kind");

    a_reg_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_REG) |-> (m_reg_addr == REG_MINUTES
                                             || m_reg_addr == REG_HOURS))
        else $error("bad rtc register address");

    // supply-on results always close the tick
    a_supply_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_SUPPLY && m_supply_on) |-> m_last)
        else $error("supply on not last");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_last)))
        else $error("result changed while stalled");

endmodule

bind clock_display_mode_controller cdmc_checker u_cdmc_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_kind,
    .m_reg_addr, .m_supply_on, .m_last
);

// ===== bench/clock_display_mode_controller_tb.sv =====
// ----------------------------------------------------------------------------
// clock display mode controller testbench
// Drives loop ticks with button and rtc readings, predicts tube updates,
// rtc writes and supply switches per tick and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_display_mode_controller_tb;
    import cdmc_pkg::*;

    typedef struct packed {
        logic [2:0] lv;     // {mode, minute, hour}
        logic       tv;
        tm_t        rtc;
    } tick_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] d1, d2, d3, d4;
        logic       dot;
        logic [1:0] addr;
        logic [7:0] data;
        logic       supply;
        logic       last;
    } disp_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_hour_button_level = 1'b1, s_minute_button_level = 1'b1;
    logic s_mode_button_level = 1'b1, s_time_valid = 1'b0;
    logic [2:0] s_rtc_second_tens = '0, s_rtc_minute_tens = '0;
    logic [3:0] s_rtc_second_ones = '0, s_rtc_minute_ones = '0, s_rtc_hour_ones = '0;
    logic s_rtc_hour_tens = 1'b0, s_rtc_pm = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_kind, m_reg_addr;
    logic [3:0] m_digit_first, m_digit_second, m_digit_third, m_digit_fourth;
    logic m_dot_on, m_supply_on, m_last;
    logic [7:0] m_reg_data;

    clock_display_mode_controller u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [15:0] mdl_press [3];
    logic [15:0] mdl_hold [3];
    logic [1:0]  mdl_mode;
    logic        mdl_power, mdl_override;
    tm_t         mdl_now, mdl_start, mdl_stop;
    logic [9:0]  mdl_dot;
    logic [7:0]  mdl_cyc_cnt;
    logic [3:0]  mdl_cyc_digit;
    logic [2:0]  mdl_lv;

    tick_item_t   pending_ticks[$];
    disp_result_t expected_results[$];
    int errors = 0, n_results = 0, n_ticks = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit stall_recv = 0, drained_pause = 0;

    function automatic bit sample_press(int b);
        mdl_press[b] = {mdl_press[b][14:0], mdl_lv[b]} | DB_FILL;
        return mdl_press[b] == DB_PRESS;
    endfunction

    function automatic bit sample_hold(int b);
        mdl_hold[b] = {mdl_hold[b][14:0], mdl_lv[b]} | DB_FILL;
        return mdl_hold[b] == DB_FILL;
    endfunction

    function automatic int hours_of(tm_t t);
        return t.ht * 10 + t.ho;
    endfunction

    function automatic int minutes_of(tm_t t);
        return t.mt * 10 + t.mo;
    endfunction

    function automatic bit times_equal(tm_t a, tm_t b);
        return a.pm == b.pm && hours_of(a) == hours_of(b) && minutes_of(a) == minutes_of(b);
    endfunction

    function automatic tm_t bump_hour(tm_t t);
        int h;
        h = hours_of(t);
        if (h < 9) t.ho = t.ho + 4'd1;
        else if (h == 9) begin
            t.ht = 1'b1;
            t.ho = 4'd0;
        end else if (h < 12) begin
            t.ho = t.ho + 4'd1;
            if (h == 11) t.pm = ~t.pm;
        end else begin
            t.ht = 1'b0;
            t.ho = 4'd1;
        end
        return t;
    endfunction

    function automatic tm_t bump_minute(tm_t t);
        if (t.mo % 10 != 9) t.mo = t.mo + 4'd1;
        else if (t.mt == 3'd5) begin
            t.mo = 4'd0;
            t.mt = 3'd0;
            t = bump_hour(t);
        end else begin
            t.mo = 4'd0;
            t.mt = t.mt + 3'd1;
        end
        return t;
    endfunction

    function automatic disp_result_t tube(int a, int b, int c, int d, bit dot);
        disp_result_t r;
        r = '0;
        r.kind = KIND_TUBE;
        r.d1 = 4'(a); r.d2 = 4'(b); r.d3 = 4'(c); r.d4 = 4'(d);
        r.dot = dot;
        return r;
    endfunction

    function automatic disp_result_t rtc_write(logic [1:0] addr, logic [7:0] data);
        disp_result_t r;
        r = '0;
        r.kind = KIND_REG;
        r.addr = addr;
        r.data = data;
        return r;
    endfunction

    function automatic disp_result_t supply_switch(bit on);
        disp_result_t r;
        r = '0;
        r.kind = KIND_SUPPLY;
        r.supply = on;
        return r;
    endfunction

    // edit one time in a set mode and return the tube update
    function automatic disp_result_t edit_shown(ref tm_t t, input int top);
        int tens, ones, v;
        if (sample_press(0)) t = bump_hour(t);
        else if (sample_press(1)) t = bump_minute(t);
        mdl_dot = (mdl_dot >= top) ? 10'd0 : mdl_dot + 10'd1;
        tens = t.ht;
        ones = t.ho;
        if (t.pm) begin
            if (!(tens == 1 && ones == 2)) begin
                v = hours_of(t) + 12;
                tens = v / 10;
                ones = v % 10;
            end
        end else if (tens == 1 && ones == 2) begin
            tens = 0;
            ones = 0;
        end
        return tube(t.mo, t.mt, ones, tens, mdl_dot < 128);
    endfunction

    task automatic predict_tick(tick_item_t it);
        disp_result_t res[$];
        mdl_lv = it.lv;
        if (it.tv) mdl_now = it.rtc;
        if (!mdl_power) begin
            if (sample_press(0) || sample_press(1) || sample_press(2)) begin
                mdl_power = 1; mdl_override = 1;
                res.push_back(supply_switch(1));
            end else if (times_equal(mdl_now, mdl_stop)) begin
                mdl_power = 1; mdl_override = 0;
                res.push_back(supply_switch(1));
            end
        end else if (sample_hold(0) && sample_hold(1)) begin
            mdl_start = '0;
            mdl_stop = '0;
        end else if (sample_press(2)) begin
            mdl_mode = mdl_mode + 2'd1;
        end else if (mdl_mode == MODE_SET) begin
            res.push_back(edit_shown(mdl_now, 255));
            res.push_back(rtc_write(REG_MINUTES, {1'b0, mdl_now.mt, mdl_now.mo}));
            res.push_back(rtc_write(REG_HOURS,
                {2'b01, mdl_now.pm, mdl_now.ht, mdl_now.ho}));
        end else if (mdl_mode == MODE_START) begin
            res.push_back(edit_shown(mdl_start, 511));
        end else if (mdl_mode == MODE_STOP) begin
            res.push_back(edit_shown(mdl_stop, 1023));
        end else if (!mdl_now.pm && hours_of(mdl_now) == 3 && minutes_of(mdl_now) < 30) begin
            mdl_cyc_cnt = mdl_cyc_cnt + 8'd1;
            if (mdl_cyc_cnt == 8'd255)
                mdl_cyc_digit = (mdl_cyc_digit == 4'd9) ? 4'd0 : mdl_cyc_digit + 4'd1;
            res.push_back(tube(mdl_cyc_digit, mdl_cyc_digit, mdl_cyc_digit, mdl_cyc_digit, 0));
        end else if (sample_hold(0)) begin
            res.push_back(tube(mdl_now.so, mdl_now.st, mdl_now.mo, mdl_now.mt, 1));
        end else begin
            if (!mdl_override && times_equal(mdl_now, mdl_start)) begin
                if (!times_equal(mdl_stop, mdl_start)) begin
                    mdl_power = 0; mdl_override = 0;
                    res.push_back(supply_switch(0));
                end
            end else if (times_equal(mdl_now, mdl_stop)) begin
                mdl_override = 0;
            end
            res.push_back(tube(mdl_now.mo, mdl_now.mt, mdl_now.ho, mdl_now.ht, 1));
        end
        if (res.size() > 0) res[res.size()-1].last = 1'b1;
        foreach (res[i]) expected_results.push_back(res[i]);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch at result %0d: %s got %0d expected %0d", n_results, what, got, want);
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_tick(pending_ticks.pop_front());
                n_ticks++;
            end
            if (!(s_valid && !s_ready)) begin
                if (pending_ticks.size() > 0 && !drained_pause &&
                    $urandom_range(99) >= send_idle_pct) begin
                    tick_item_t it;
                    it = pending_ticks[0];
                    s_valid <= 1'b1;
                    {s_mode_button_level, s_minute_button_level, s_hour_button_level} <= it.lv;
                    s_time_valid <= it.tv;
                    s_rtc_second_tens <= it.rtc.st; s_rtc_second_ones <= it.rtc.so;
                    s_rtc_minute_tens <= it.rtc.mt; s_rtc_minute_ones <= it.rtc.mo;
                    s_rtc_hour_tens <= it.rtc.ht; s_rtc_hour_ones <= it.rtc.ho;
                    s_rtc_pm <= it.rtc.pm;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                disp_result_t w;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, kind", m_kind, 0);
                end else begin
                    w = expected_results.pop_front();
                    if (m_kind != w.kind) report_mismatch("kind", m_kind, w.kind);
                    if (m_digit_first != w.d1) report_mismatch("digit_first", m_digit_first, w.d1);
                    if (m_digit_second != w.d2) report_mismatch("digit_second", m_digit_second, w.d2);
                    if (m_digit_third != w.d3) report_mismatch("digit_third", m_digit_third, w.d3);
                    if (m_digit_fourth != w.d4) report_mismatch("digit_fourth", m_digit_fourth, w.d4);
                    if (m_dot_on != w.dot) report_mismatch("dot_on", m_dot_on, w.dot);
                    if (m_reg_addr != w.addr) report_mismatch("reg_addr", m_reg_addr, w.addr);
                    if (m_reg_data != w.data) report_mismatch("reg_data", m_reg_data, w.data);
                    if (m_supply_on != w.supply) report_mismatch("supply_on", m_supply_on, w.supply);
                    if (m_last != w.last) report_mismatch("last", m_last, w.last);
                end
                n_results++;
            end
            m_ready <= !stall_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    int quiet = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
        else quiet++;
        if (quiet > 5000) begin
            $display("watchdog expired");
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic tm_t rand_time();
        tm_t t;
        t.st = 3'($urandom_range(7));
        t.so = 4'($urandom_range(15));
        t.mt = 3'($urandom_range(7));
        t.mo = 4'($urandom_range(15));
        t.ht = 1'($urandom_range(1));
        t.ho = 4'($urandom_range(15));
        t.pm = 1'($urandom_range(1));
        return t;
    endfunction

    function automatic tm_t hm_time(int h, int m, bit pm);
        tm_t t;
        t = '0;
        t.ht = 1'(h / 10); t.ho = 4'(h % 10);
        t.mt = 3'(m / 10); t.mo = 4'(m % 10);
        t.pm = pm;
        return t;
    endfunction

    // a button held for n ticks, then released
    task automatic push_button(logic [2:0] mask, int n, bit tv, tm_t t);
        tick_item_t it;
        for (int i = 0; i < n; i++) begin
            it.lv = ~mask;
            it.tv = (i == 0) ? tv : 1'b0;
            it.rtc = t;
            pending_ticks.push_back(it);
        end
        it.lv = 3'b111; it.tv = 0; it.rtc = t;
        pending_ticks.push_back(it);
    endtask

    task automatic add_tick(logic [2:0] lv, bit tv, tm_t t);
        tick_item_t it;
        it.lv = lv; it.tv = tv; it.rtc = t;
        pending_ticks.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic random_stretch(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(9);
            if (k < 3) push_button(3'($urandom_range(1, 7)), $urandom_range(11, 16),
                                   $urandom_range(1), rand_time());
            else if (k < 5) add_tick(3'b111, 1, hm_time($urandom_range(1, 12),
                                     $urandom_range(59), $urandom_range(1)));
            else if (k < 6) add_tick(3'b111, 1, hm_time(3, $urandom_range(35), 0));
            else add_tick(3'($urandom()), $urandom_range(1), rand_time());
        end
    endtask

    initial begin
        mdl_press = '{default: '0};
        mdl_hold = '{default: '0};
        mdl_mode = MODE_SHOW; mdl_power = 1; mdl_override = 0;
        mdl_now = '0; mdl_start = '0; mdl_stop = '0;
        mdl_dot = '0; mdl_cyc_cnt = '0; mdl_cyc_digit = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: show time extremes, 3 am cycling, hold 0, modes and edits
        add_tick(3'b111, 1, hm_time(12, 59, 1));
        add_tick(3'b111, 1, hm_time(3, 10, 0));
        add_tick(3'b111, 1, '1);
        push_button(3'b001, 14, 1, hm_time(11, 59, 0));
        push_button(3'b100, 12, 0, '0);                 // to set time
        push_button(3'b001, 12, 0, '0);                 // hour inc with am/pm roll
        push_button(3'b010, 12, 1, hm_time(9, 59, 1));  // minute carry into hour
        push_button(3'b100, 12, 0, '0);                 // to start time
        push_button(3'b010, 12, 0, '0);
        push_button(3'b100, 12, 0, '0);                 // to stop time
        push_button(3'b011, 15, 0, '0);                 // both held clears schedule
        push_button(3'b100, 12, 0, '0);                 // back to show
        wait_drained();

        // supply off at the start time, then override by button
        drained_pause = 0;
        add_tick(3'b111, 1, hm_time(1, 5, 0));
        push_button(3'b100, 12, 0, '0);
        push_button(3'b100, 12, 0, '0);
        push_button(3'b010, 12, 0, '0);
        push_button(3'b100, 12, 0, '0);
        push_button(3'b100, 12, 0, '0);
        add_tick(3'b111, 1, hm_time(12, 1, 0));
        add_tick(3'b111, 0, '0);
        add_tick(3'b111, 1, hm_time(12, 0, 0));         // stop time restores supply
        add_tick(3'b111, 1, hm_time(12, 1, 0));
        push_button(3'b001, 12, 0, '0);                 // override restores supply
        wait_drained();

        // long receiver stall while the sender keeps offering
        random_stretch(6);
        stall_recv = 1;
        repeat (300) @(posedge aclk);
        stall_recv = 0;
        wait_drained();

        send_idle_pct = 22; recv_idle_pct = 73;
        random_stretch(12);
        wait_drained();
        send_idle_pct = 73; recv_idle_pct = 22;
        random_stretch(12);
        wait_drained();
        // sender waits for every outstanding result before continuing
        drained_pause = 1;
        wait_drained();
        drained_pause = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        random_stretch(12);
        wait_drained();

        $display("ticks accepted: %0d, results checked: %0d", n_ticks, n_results);
        $display("covered modes, edits, schedule, supply switching and long stalls");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
